// File: hdl/rrts_pkg.sv
// Shared types and codes for the round robin task scheduler.
package rrts_pkg;

    // Request and result beats.
    typedef struct packed {
        logic [1:0] operation;
        logic [5:0] task_id;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] granted_slot;
        logic       do_jump;
        logic [5:0] next_task;
        logic [6:0] running_count;
    } rsp_t;

    // Operation codes.
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_SLEEP = 2'd3;

    // Result status codes.
    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_NOFREE  = 2'd1;
    localparam logic [1:0] STATUS_IGNORED = 2'd2;

    // Stored slot flags. A free slot is never stored: every slot at or above
    // the allocation count is free.
    localparam logic [1:0] FLAG_IDLE = 2'd1;
    localparam logic [1:0] FLAG_RUN  = 2'd2;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_FINISH,
        S_JUMP,
        S_RESP
    } state_t;

endpackage

// File: hdl/round_robin_task_scheduler.sv
// Top level of the round robin task scheduler with its slot and run list memories.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+------------------------------------
//   req     | in  | req_valid/req_ready  | rrts_pkg::req_t (operation, task_id)
//   rsp     | out | rsp_valid/rsp_ready  | rrts_pkg::rsp_t (status .. running_count)
//
// Path of a request: allocate goes straight to the response state; run passes a
// check state; tick reads the next run list entry in a jump state (skipped when
// fewer than two tasks run); sleep checks, walks the run list once through the one
// read port of the run list memory, finishes, and jumps when control jumps.
// Reset leads into an initialization state that marks slot 0 running and
// places it in run list entry 0; req_ready stays low in that state.
// A finished result sits in the rsp output register, so the next request is
// taken while the previous result still waits for rsp_ready.
module round_robin_task_scheduler #(
    parameter int MAX_SLOTS = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  rrts_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output rrts_pkg::rsp_t  rsp
);

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int LEN_W  = $clog2(MAX_SLOTS + 1);

    // Slot flag memory and run list memory. Both are simple dual port with a
    // registered read. Flag data read at or above alloc_cnt_reg, and run list data
    // read at or above len_reg, is never used.
    logic [1:0] flag_mem [MAX_SLOTS];
    logic [5:0] list_mem [MAX_SLOTS];

    logic [SLOT_W-1:0] flag_raddr;
    logic [1:0]        flag_rdata_reg;
    logic              flag_we;
    logic [SLOT_W-1:0] flag_waddr;
    logic [1:0]        flag_wdata;

    logic [SLOT_W-1:0] list_raddr;
    logic [5:0]        list_rdata_reg;
    logic              list_we;
    logic [SLOT_W-1:0] list_waddr;
    logic [5:0]        list_wdata;

    // Control state.
    rrts_pkg::state_t  state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [SLOT_W-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0]  alloc_cnt_reg, alloc_cnt_next;
    logic [LEN_W-1:0]  scan_addr_reg, scan_addr_next;
    logic              rvalid_reg, rvalid_next;
    logic              found_reg, found_next;
    logic              out_valid_reg, out_valid_next;

    // Payload state.
    rrts_pkg::req_t    cmd_reg, cmd_next;
    logic [SLOT_W-1:0] ridx_reg, ridx_next;
    logic [SLOT_W-1:0] found_idx_reg, found_idx_next;
    rrts_pkg::rsp_t    res_reg, res_next;
    rrts_pkg::rsp_t    out_reg, out_next;

    // Helpers for the combinational block.
    logic              id_ok;
    logic [LEN_W-1:0]  tick_pos;
    logic [SLOT_W-1:0] last_idx;
    logic [LEN_W-1:0]  new_len;
    logic [SLOT_W-1:0] adj_pos;
    logic              was_current;
    rrts_pkg::rsp_t    res_blank;

    assign req_ready = (state_reg == rrts_pkg::S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // Memories: read every cycle, write when enabled.
    always_ff @(posedge clk)
    begin
        if (flag_we)
        begin
            flag_mem[flag_waddr] <= flag_wdata;
        end
        flag_rdata_reg <= flag_mem[flag_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
        begin
            list_mem[list_waddr] <= list_wdata;
        end
        list_rdata_reg <= list_mem[list_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rrts_pkg::S_INIT;
            len_reg       <= LEN_W'(1);
            pos_reg       <= '0;
            alloc_cnt_reg <= LEN_W'(1);
            scan_addr_reg <= '0;
            rvalid_reg    <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            alloc_cnt_reg <= alloc_cnt_next;
            scan_addr_reg <= scan_addr_next;
            rvalid_reg    <= rvalid_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        ridx_reg      <= ridx_next;
        found_idx_reg <= found_idx_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        alloc_cnt_next = alloc_cnt_reg;
        scan_addr_next = scan_addr_reg;
        rvalid_next    = 1'b0;
        found_next     = found_reg;
        out_valid_next = out_valid_reg;
        cmd_next       = cmd_reg;
        ridx_next      = ridx_reg;
        found_idx_next = found_idx_reg;
        res_next       = res_reg;
        out_next       = out_reg;

        flag_raddr = '0;
        flag_we    = 1'b0;
        flag_waddr = '0;
        flag_wdata = rrts_pkg::FLAG_IDLE;
        list_raddr = '0;
        list_we    = 1'b0;
        list_waddr = '0;
        list_wdata = '0;

        res_blank               = '0;
        res_blank.status        = rrts_pkg::STATUS_DONE;
        res_blank.running_count = 7'(len_reg);

        // A slot number names an allocated slot only below the allocation count.
        id_ok = (32'(cmd_reg.task_id) < 32'(alloc_cnt_reg));

        tick_pos = LEN_W'(pos_reg) + LEN_W'(1);
        if (tick_pos >= len_reg)
        begin
            tick_pos = '0;
        end

        last_idx = SLOT_W'(len_reg - LEN_W'(1));
        new_len  = len_reg - LEN_W'(1);

        // Position after removing the entry at found_idx_reg.
        was_current = (found_idx_reg == pos_reg);
        adj_pos     = (found_idx_reg < pos_reg) ? (pos_reg - SLOT_W'(1)) : pos_reg;
        if (LEN_W'(adj_pos) >= new_len)
        begin
            adj_pos = '0;
        end

        // The output register frees up when its beat is taken.
        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            rrts_pkg::S_INIT:
            begin
                flag_we    = 1'b1;
                flag_waddr = '0;
                flag_wdata = rrts_pkg::FLAG_RUN;
                list_we    = 1'b1;
                list_waddr = '0;
                list_wdata = '0;
                state_next = rrts_pkg::S_IDLE;
            end

            rrts_pkg::S_IDLE:
            begin
                flag_raddr = SLOT_W'(req.task_id);
                if (req_valid)
                begin
                    cmd_next = req;
                    unique case (req.operation)
                        rrts_pkg::OP_ALLOC:
                        begin
                            // Free slots always form the range from the
                            // allocation count to the top, so the lowest one
                            // is the count itself.
                            res_next = res_blank;
                            if (32'(alloc_cnt_reg) < MAX_SLOTS)
                            begin
                                flag_we                = 1'b1;
                                flag_waddr             = SLOT_W'(alloc_cnt_reg);
                                flag_wdata             = rrts_pkg::FLAG_IDLE;
                                alloc_cnt_next         = alloc_cnt_reg + LEN_W'(1);
                                res_next.granted_slot  = 6'(alloc_cnt_reg);
                            end
                            else
                            begin
                                res_next.status = rrts_pkg::STATUS_NOFREE;
                            end
                            state_next = rrts_pkg::S_RESP;
                        end
                        rrts_pkg::OP_TICK:
                        begin
                            if (len_reg >= LEN_W'(2))
                            begin
                                pos_next   = SLOT_W'(tick_pos);
                                list_raddr = SLOT_W'(tick_pos);
                                state_next = rrts_pkg::S_JUMP;
                            end
                            else
                            begin
                                res_next   = res_blank;
                                state_next = rrts_pkg::S_RESP;
                            end
                        end
                        default:
                        begin
                            state_next = rrts_pkg::S_CHECK;
                        end
                    endcase
                end
            end

            rrts_pkg::S_CHECK:
            begin
                res_next        = res_blank;
                res_next.status = rrts_pkg::STATUS_IGNORED;
                state_next      = rrts_pkg::S_RESP;
                if (cmd_reg.operation == rrts_pkg::OP_RUN)
                begin
                    if (id_ok && flag_rdata_reg == rrts_pkg::FLAG_IDLE
                        && 32'(len_reg) < MAX_SLOTS)
                    begin
                        flag_we    = 1'b1;
                        flag_waddr = SLOT_W'(cmd_reg.task_id);
                        flag_wdata = rrts_pkg::FLAG_RUN;
                        list_we    = 1'b1;
                        list_waddr = SLOT_W'(len_reg);
                        list_wdata = cmd_reg.task_id;
                        len_next   = len_reg + LEN_W'(1);
                        res_next.status        = rrts_pkg::STATUS_DONE;
                        res_next.running_count = 7'(len_reg + LEN_W'(1));
                    end
                end
                else if (id_ok && flag_rdata_reg == rrts_pkg::FLAG_RUN)
                begin
                    scan_addr_next = '0;
                    found_next     = 1'b0;
                    state_next     = rrts_pkg::S_SCAN;
                end
            end

            rrts_pkg::S_SCAN:
            begin
                // Read the list front to back; once the slot is found, each
                // later entry is written back one place lower.
                if (scan_addr_reg < len_reg)
                begin
                    list_raddr     = SLOT_W'(scan_addr_reg);
                    ridx_next      = SLOT_W'(scan_addr_reg);
                    rvalid_next    = 1'b1;
                    scan_addr_next = scan_addr_reg + LEN_W'(1);
                end
                if (rvalid_reg)
                begin
                    if (found_reg)
                    begin
                        list_we    = 1'b1;
                        list_waddr = ridx_reg - SLOT_W'(1);
                        list_wdata = list_rdata_reg;
                    end
                    else if (list_rdata_reg == cmd_reg.task_id)
                    begin
                        found_next     = 1'b1;
                        found_idx_next = ridx_reg;
                    end
                    if (ridx_reg == last_idx)
                    begin
                        if (found_next)
                        begin
                            state_next = rrts_pkg::S_FINISH;
                        end
                        else
                        begin
                            res_next        = res_blank;
                            res_next.status = rrts_pkg::STATUS_IGNORED;
                            state_next      = rrts_pkg::S_RESP;
                        end
                    end
                end
            end

            rrts_pkg::S_FINISH:
            begin
                flag_we    = 1'b1;
                flag_waddr = SLOT_W'(cmd_reg.task_id);
                flag_wdata = rrts_pkg::FLAG_IDLE;
                len_next   = new_len;
                pos_next   = adj_pos;
                if (was_current && new_len != '0)
                begin
                    list_raddr = adj_pos;
                    state_next = rrts_pkg::S_JUMP;
                end
                else
                begin
                    res_next               = res_blank;
                    res_next.running_count = 7'(new_len);
                    state_next             = rrts_pkg::S_RESP;
                end
            end

            rrts_pkg::S_JUMP:
            begin
                res_next           = res_blank;
                res_next.do_jump   = 1'b1;
                res_next.next_task = list_rdata_reg;
                state_next         = rrts_pkg::S_RESP;
            end

            rrts_pkg::S_RESP:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = rrts_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = rrts_pkg::S_IDLE;
            end
        endcase
    end

    // The current position always lies inside the list, or is zero when empty.
    a_pos_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (LEN_W'(pos_reg) < len_reg || len_reg == '0) && LEN_W'(pos_reg) < MAX_SLOTS)
        else $error("current position outside the run list");

    // Running tasks are a subset of allocated slots.
    a_len_le_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= alloc_cnt_reg && 32'(alloc_cnt_reg) <= MAX_SLOTS)
        else $error("run list longer than the allocated slot count");

    // A result beat only appears after the response state loaded it.
    a_rsp_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == rrts_pkg::S_RESP)
        else $error("result beat raised outside the response state");

    // A jump is only ever reported together with a completed request.
    a_jump_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.do_jump |-> out_reg.status == rrts_pkg::STATUS_DONE)
        else $error("jump reported with a failing status");

endmodule
